/* hw/rtl/ellipse_frame_vector_angle_core_assert.svh */
// ----------------------------------------------------------------------------
// Ellipse frame vector angle: assertion macros
// Concurrent checks on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ELLIPSE_FRAME_VECTOR_ANGLE_CORE_ASSERT_SVH
`define ELLIPSE_FRAME_VECTOR_ANGLE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define EFVA_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("efva: check failed");
`define EFVA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("efva: check failed");
`else
`define EFVA_ASSERT_IMPLIES(lbl, ante, cons)
`define EFVA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/efva_pkg.sv */
// ----------------------------------------------------------------------------
// Ellipse frame vector angle: package
// Widths, register indexes, transaction types and the arctangent table.
// ----------------------------------------------------------------------------
package efva_pkg;

   localparam int ANGLE_BITS      = 16;
   localparam int COORD_WIDTH     = 32;
   localparam int RADIUS_WIDTH    = 32;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam int AXIS_WIDTH   = 18;
   localparam int CROSS_WIDTH  = 21;
   localparam int TURN_WIDTH   = 32;
   localparam int CORDIC_STEPS = 30;
   localparam int STEP_WIDTH   = 5;

   localparam int VEC_WIDTH   = 41;
   localparam int EXT_WIDTH   = (COORD_WIDTH > VEC_WIDTH) ? COORD_WIDTH : VEC_WIDTH;
   localparam int PRE_SHW     = $clog2(EXT_WIDTH - VEC_WIDTH + 2);
   localparam int UPROD_WIDTH = AXIS_WIDTH + VEC_WIDTH;
   localparam int WPROD_WIDTH = CROSS_WIDTH + VEC_WIDTH;
   localparam int PROJ_WIDTH  = 61;
   localparam int CHECK_WIDTH = 64;
   localparam int MAG_WIDTH   = 30;
   localparam int NORM_SHW    = $clog2(PROJ_WIDTH - MAG_WIDTH + 1);
   localparam int BX_WIDTH    = 2 * MAG_WIDTH;
   localparam int CW          = 64;
   localparam int ZW          = 33;
   localparam int STEPS_PER_STAGE = 3;
   localparam int VEC_STAGES  = CORDIC_STEPS / STEPS_PER_STAGE;

   localparam logic [TURN_WIDTH-1:0] QUARTER = 32'h4000_0000;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_RADIUS_X = 3'd0,
      CSR_RADIUS_Y = 3'd1,
      CSR_TILT     = 3'd2,
      CSR_HEADING  = 3'd3,
      CSR_ROLL     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] vector_x;
      logic signed [COORD_WIDTH-1:0] vector_y;
      logic signed [COORD_WIDTH-1:0] vector_z;
   } req_type;

   typedef struct packed {
      logic [ANGLE_BITS-1:0] plane_angle;
      logic                  degenerate;
   } rsp_type;

   typedef struct packed {
      logic [2:0][AXIS_WIDTH-1:0]  u;
      logic [2:0][AXIS_WIDTH-1:0]  s;
      logic [2:0][CROSS_WIDTH-1:0] w;
   } frame_type;

   typedef struct packed {
      logic valid;
      logic zero;
      logic degen;
      logic bx_zero;
      logic by_zero;
      logic p_neg;
      logic t_neg;
   } ctl_type;

   function automatic logic [TURN_WIDTH-1:0] atan_turn(input logic [STEP_WIDTH-1:0] i);
      logic [TURN_WIDTH-1:0] r;
      unique case (i)
         5'd0:  r = 32'd536870912;
         5'd1:  r = 32'd316933406;
         5'd2:  r = 32'd167458907;
         5'd3:  r = 32'd85004756;
         5'd4:  r = 32'd43149635;
         5'd5:  r = 32'd21354465;
         5'd6:  r = 32'd10680862;
         5'd7:  r = 32'd5340245;
         5'd8:  r = 32'd2670163;
         5'd9:  r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;
         5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;
         5'd19: r = 32'd1304;
         5'd20: r = 32'd652;
         5'd21: r = 32'd326;
         5'd22: r = 32'd163;
         5'd23: r = 32'd81;
         5'd24: r = 32'd41;
         5'd25: r = 32'd20;
         5'd26: r = 32'd10;
         5'd27: r = 32'd5;
         5'd28: r = 32'd3;
         5'd29: r = 32'd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

/* hw/rtl/efva_frame.sv */
// ----------------------------------------------------------------------------
// Ellipse frame vector angle: frame builder
// Sequencer with one CORDIC rotator and one multiplier; rebuilds the axes
// u, s and the check vector n x u after reset or an angle write.
// ----------------------------------------------------------------------------
module efva_frame
   import efva_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [ANGLE_BITS-1:0] tilt_angle,
   input  logic [ANGLE_BITS-1:0] heading_angle,
   input  logic [ANGLE_BITS-1:0] roll_angle,
   output frame_type             frame,
   output logic                  busy
);

   localparam int TRIG_WIDTH = 33;
   localparam int MUL_WIDTH  = 2 * AXIS_WIDTH;
   localparam int ACC_WIDTH  = MUL_WIDTH + 2;
   localparam logic signed [TRIG_WIDTH-1:0] CORDIC_GAIN = 652032874;
   localparam logic signed [TRIG_WIDTH-1:0] TRIG_ONE    = 65536;
   localparam logic signed [ACC_WIDTH-1:0]  AXIS_MAX    = 131071;
   localparam logic signed [ACC_WIDTH-1:0]  AXIS_MIN    = -131072;
   localparam logic [STEP_WIDTH-1:0] ROT_LAST  = STEP_WIDTH'(CORDIC_STEPS - 1);
   localparam logic [STEP_WIDTH-1:0] PROD_LAST = 5'd19;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_LOAD  = 5'b00010,
      ST_ROT   = 5'b00100,
      ST_STORE = 5'b01000,
      ST_PROD  = 5'b10000
   } state_type;

   typedef enum logic [3:0] {
      DST_A, DST_B, DST_U0, DST_U1, DST_U2, DST_S0, DST_S1, DST_S2,
      DST_N0, DST_N1, DST_W0, DST_W1, DST_W2
   } dest_type;

   function automatic logic signed [AXIS_WIDTH-1:0] clamp_trig(
      input logic signed [TRIG_WIDTH-1:0] v);
      logic signed [AXIS_WIDTH-1:0] r;
      if (v > TRIG_ONE) r = AXIS_WIDTH'(TRIG_ONE);
      else if (v < -TRIG_ONE) r = AXIS_WIDTH'(-TRIG_ONE);
      else r = AXIS_WIDTH'(v);
      return r;
   endfunction

   function automatic logic signed [AXIS_WIDTH-1:0] clamp_axis(
      input logic signed [ACC_WIDTH-1:0] v);
      logic signed [AXIS_WIDTH-1:0] r;
      if (v > AXIS_MAX) r = AXIS_WIDTH'(AXIS_MAX);
      else if (v < AXIS_MIN) r = AXIS_WIDTH'(AXIS_MIN);
      else r = AXIS_WIDTH'(v);
      return r;
   endfunction

   state_type                     state_ff, state_in;
   logic [1:0]                    sel_ff, sel_in;
   logic [STEP_WIDTH-1:0]         step_ff, step_in;
   logic [1:0]                    quad_ff, quad_in;
   logic signed [TRIG_WIDTH-1:0]  rx_ff, rx_in, ry_ff, ry_in;
   logic signed [TURN_WIDTH-1:0]  rz_ff, rz_in;
   logic signed [AXIS_WIDTH-1:0]  ct_ff, ct_in, st_ff, st_in, cp_ff, cp_in;
   logic signed [AXIS_WIDTH-1:0]  sp_ff, sp_in, ca_ff, ca_in, sa_ff, sa_in;
   logic signed [AXIS_WIDTH-1:0]  a_ff, a_in, b_ff, b_in;
   logic signed [ACC_WIDTH-1:0]   acc_ff, acc_in;
   logic signed [AXIS_WIDTH-1:0]  u_ff [3];
   logic signed [AXIS_WIDTH-1:0]  u_in [3];
   logic signed [AXIS_WIDTH-1:0]  s_ff [3];
   logic signed [AXIS_WIDTH-1:0]  s_in [3];
   logic signed [AXIS_WIDTH-1:0]  n_ff [3];
   logic signed [AXIS_WIDTH-1:0]  n_in [3];
   logic signed [CROSS_WIDTH-1:0] w_ff [3];
   logic signed [CROSS_WIDTH-1:0] w_in [3];

   logic [ANGLE_BITS-1:0]         ang;
   logic [TURN_WIDTH-1:0]         turn;
   logic signed [TRIG_WIDTH-1:0]  dx, dy, cr_full, sr_full;
   logic signed [TURN_WIDTH-1:0]  atan_s;
   logic signed [AXIS_WIDTH-1:0]  cr, sr, cv, sv;
   logic signed [AXIS_WIDTH-1:0]  op_a, op_b;
   logic                          neg, first, last, raw;
   dest_type                      dest;
   logic signed [MUL_WIDTH-1:0]   prod, prod_rnd;
   logic signed [ACC_WIDTH-1:0]   term, acc_new, acc_rnd;
   logic signed [AXIS_WIDTH-1:0]  axis_val;

   always_comb begin
      op_a  = ct_ff;
      op_b  = sp_ff;
      neg   = 1'b0;
      first = 1'b1;
      last  = 1'b1;
      raw   = 1'b0;
      dest  = DST_A;
      unique case (step_ff)
         5'd0:  begin op_a = ct_ff; op_b = sp_ff; dest = DST_A; end
         5'd1:  begin op_a = ct_ff; op_b = cp_ff; dest = DST_B; end
         5'd2:  begin op_a = cp_ff; op_b = ca_ff; last = 1'b0; end
         5'd3:  begin op_a = a_ff; op_b = sa_ff; neg = 1'b1; first = 1'b0; dest = DST_U0; end
         5'd4:  begin op_a = sp_ff; op_b = ca_ff; last = 1'b0; end
         5'd5:  begin op_a = b_ff; op_b = sa_ff; first = 1'b0; dest = DST_U1; end
         5'd6:  begin op_a = st_ff; op_b = sa_ff; dest = DST_U2; end
         5'd7:  begin op_a = cp_ff; op_b = sa_ff; neg = 1'b1; last = 1'b0; end
         5'd8:  begin op_a = a_ff; op_b = ca_ff; neg = 1'b1; first = 1'b0; dest = DST_S0; end
         5'd9:  begin op_a = sp_ff; op_b = sa_ff; neg = 1'b1; last = 1'b0; end
         5'd10: begin op_a = b_ff; op_b = ca_ff; first = 1'b0; dest = DST_S1; end
         5'd11: begin op_a = st_ff; op_b = ca_ff; dest = DST_S2; end
         5'd12: begin op_a = st_ff; op_b = sp_ff; dest = DST_N0; end
         5'd13: begin op_a = st_ff; op_b = cp_ff; neg = 1'b1; dest = DST_N1; end
         5'd14: begin op_a = n_ff[1]; op_b = u_ff[2]; raw = 1'b1; last = 1'b0; end
         5'd15: begin
            op_a = n_ff[2]; op_b = u_ff[1]; raw = 1'b1; neg = 1'b1; first = 1'b0;
            dest = DST_W0;
         end
         5'd16: begin op_a = n_ff[2]; op_b = u_ff[0]; raw = 1'b1; last = 1'b0; end
         5'd17: begin
            op_a = n_ff[0]; op_b = u_ff[2]; raw = 1'b1; neg = 1'b1; first = 1'b0;
            dest = DST_W1;
         end
         5'd18: begin op_a = n_ff[0]; op_b = u_ff[1]; raw = 1'b1; last = 1'b0; end
         5'd19: begin
            op_a = n_ff[1]; op_b = u_ff[0]; raw = 1'b1; neg = 1'b1; first = 1'b0;
            dest = DST_W2;
         end
         default: begin op_a = '0; op_b = '0; last = 1'b0; end
      endcase
   end

   always_comb begin
      prod     = op_a * op_b;
      prod_rnd = (prod + MUL_WIDTH'(32768)) >>> 16;
      term     = raw ? ACC_WIDTH'(prod) : ACC_WIDTH'(prod_rnd);
      acc_new  = (first ? '0 : acc_ff) + (neg ? -term : term);
      acc_rnd  = (acc_new + ACC_WIDTH'(32768)) >>> 16;
      axis_val = clamp_axis(acc_new);

      unique case (sel_ff)
         2'd0:    ang = tilt_angle;
         2'd1:    ang = heading_angle;
         default: ang = roll_angle;
      endcase
      turn = {ang, {(TURN_WIDTH - ANGLE_BITS){1'b0}}};

      dx     = ry_ff >>> step_ff;
      dy     = rx_ff >>> step_ff;
      atan_s = $signed(atan_turn(step_ff));

      cr_full = (rx_ff + TRIG_WIDTH'(8192)) >>> 14;
      sr_full = (ry_ff + TRIG_WIDTH'(8192)) >>> 14;
      cr      = clamp_trig(cr_full);
      sr      = clamp_trig(sr_full);
      unique case (quad_ff)
         2'd0: begin cv = cr;  sv = sr;  end
         2'd1: begin cv = -sr; sv = cr;  end
         2'd2: begin cv = -cr; sv = -sr; end
         2'd3: begin cv = sr;  sv = -cr; end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      step_in  = step_ff;
      quad_in  = quad_ff;
      rx_in    = rx_ff;
      ry_in    = ry_ff;
      rz_in    = rz_ff;
      ct_in    = ct_ff;
      st_in    = st_ff;
      cp_in    = cp_ff;
      sp_in    = sp_ff;
      ca_in    = ca_ff;
      sa_in    = sa_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      u_in     = u_ff;
      s_in     = s_ff;
      n_in     = n_ff;
      w_in     = w_ff;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_LOAD: begin
            quad_in  = turn[TURN_WIDTH-1 -: 2];
            rx_in    = CORDIC_GAIN;
            ry_in    = '0;
            rz_in    = $signed({2'b00, turn[TURN_WIDTH-3:0]});
            step_in  = '0;
            state_in = ST_ROT;
         end
         ST_ROT: begin
            if (!rz_ff[TURN_WIDTH-1]) begin
               rx_in = rx_ff - dx;
               ry_in = ry_ff + dy;
               rz_in = rz_ff - atan_s;
            end else begin
               rx_in = rx_ff + dx;
               ry_in = ry_ff - dy;
               rz_in = rz_ff + atan_s;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == ROT_LAST) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            unique case (sel_ff)
               2'd0:    begin ct_in = cv; st_in = sv; end
               2'd1:    begin cp_in = cv; sp_in = sv; end
               default: begin ca_in = cv; sa_in = sv; end
            endcase
            if (sel_ff == 2'd2) begin
               n_in[2]  = ct_ff;
               step_in  = '0;
               state_in = ST_PROD;
            end else begin
               sel_in   = sel_ff + 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_PROD: begin
            acc_in = acc_new;
            if (last) begin
               unique case (dest)
                  DST_A:  a_in    = axis_val;
                  DST_B:  b_in    = axis_val;
                  DST_U0: u_in[0] = axis_val;
                  DST_U1: u_in[1] = axis_val;
                  DST_U2: u_in[2] = axis_val;
                  DST_S0: s_in[0] = axis_val;
                  DST_S1: s_in[1] = axis_val;
                  DST_S2: s_in[2] = axis_val;
                  DST_N0: n_in[0] = axis_val;
                  DST_N1: n_in[1] = axis_val;
                  DST_W0: w_in[0] = CROSS_WIDTH'(acc_rnd);
                  DST_W1: w_in[1] = CROSS_WIDTH'(acc_rnd);
                  DST_W2: w_in[2] = CROSS_WIDTH'(acc_rnd);
                  default: begin
                  end
               endcase
            end
            step_in = step_ff + 1'b1;
            if (step_ff == PROD_LAST) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (start) begin
         sel_in   = '0;
         state_in = ST_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         sel_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quad_ff <= quad_in;
      rx_ff   <= rx_in;
      ry_ff   <= ry_in;
      rz_ff   <= rz_in;
      ct_ff   <= ct_in;
      st_ff   <= st_in;
      cp_ff   <= cp_in;
      sp_ff   <= sp_in;
      ca_ff   <= ca_in;
      sa_ff   <= sa_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      u_ff    <= u_in;
      s_ff    <= s_in;
      n_ff    <= n_in;
      w_ff    <= w_in;
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         frame.u[k] = u_ff[k];
         frame.s[k] = s_ff[k];
         frame.w[k] = w_ff[k];
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* hw/rtl/efva_project.sv */
// ----------------------------------------------------------------------------
// Ellipse frame vector angle: projection pipeline
// Input register, prescale, frame products, sums, normalisation and the
// radius cross products feeding the vectoring stages.
// ----------------------------------------------------------------------------
module efva_project
   import efva_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  req_type              in_data,
   input  frame_type            frame,
   input  logic [MAG_WIDTH-1:0] rxr,
   input  logic [MAG_WIDTH-1:0] ryr,
   output ctl_type              ctl,
   output logic [BX_WIDTH-1:0]  bx,
   output logic [BX_WIDTH-1:0]  by
);

   // stage 0: input
   logic    v0_valid_ff;
   req_type v0_ff;

   // stage 1: prescale
   logic signed [EXT_WIDTH-1:0] ext [3];
   logic [EXT_WIDTH-1:0]        ext_mag [3];
   logic [EXT_WIDTH-1:0]        m_all;
   logic [PRE_SHW-1:0]          pre_sh;
   logic signed [EXT_WIDTH-1:0] ext_sh [3];
   logic                        v1_valid_ff, v1_zero_ff;
   logic signed [VEC_WIDTH-1:0] v1_ff [3];

   // stage 2: products
   logic                          v2_valid_ff, v2_zero_ff;
   logic signed [UPROD_WIDTH-1:0] pu_ff [3];
   logic signed [UPROD_WIDTH-1:0] ps_ff [3];
   logic signed [WPROD_WIDTH-1:0] pw_ff [3];

   // stage 3: sums
   logic signed [PROJ_WIDTH-1:0]  p_sum, q_sum;
   logic signed [CHECK_WIDTH-1:0] t_sum;
   logic                          v3_valid_ff, v3_zero_ff, v3_pneg_ff, v3_tneg_ff;
   logic [PROJ_WIDTH-1:0]         v3_ax_ff, v3_ay_ff;

   // stage 4: shift count
   logic [PROJ_WIDTH-1:0]         m_proj;
   logic [NORM_SHW-1:0]           nsh;
   logic                          v4_valid_ff, v4_zero_ff, v4_pneg_ff, v4_tneg_ff;
   logic [PROJ_WIDTH-1:0]         v4_ax_ff, v4_ay_ff;
   logic [NORM_SHW-1:0]           v4_sh_ff;

   // stage 5: shift
   logic                          v5_valid_ff, v5_zero_ff, v5_pneg_ff, v5_tneg_ff;
   logic [MAG_WIDTH-1:0]          v5_ax_ff, v5_ay_ff;

   // stage 6: radius cross products
   logic [BX_WIDTH-1:0]           bx_prod, by_prod;
   ctl_type                       ctl_ff;
   logic [BX_WIDTH-1:0]           bx_ff, by_ff;

   always_comb begin
      ext[0] = EXT_WIDTH'(v0_ff.vector_x);
      ext[1] = EXT_WIDTH'(v0_ff.vector_y);
      ext[2] = EXT_WIDTH'(v0_ff.vector_z);
      for (int k = 0; k < 3; k++) begin
         ext_mag[k] = ext[k][EXT_WIDTH-1] ? EXT_WIDTH'(-ext[k]) : EXT_WIDTH'(ext[k]);
      end
      m_all  = ext_mag[0] | ext_mag[1] | ext_mag[2];
      pre_sh = '0;
      for (int b = VEC_WIDTH - 1; b < EXT_WIDTH; b++) begin
         if (m_all[b]) pre_sh = PRE_SHW'(b - (VEC_WIDTH - 2));
      end
      for (int k = 0; k < 3; k++) begin
         ext_sh[k] = ext[k] >>> pre_sh;
      end
   end

   always_comb begin
      p_sum = PROJ_WIDTH'(pu_ff[0]) + PROJ_WIDTH'(pu_ff[1]) + PROJ_WIDTH'(pu_ff[2]);
      q_sum = PROJ_WIDTH'(ps_ff[0]) + PROJ_WIDTH'(ps_ff[1]) + PROJ_WIDTH'(ps_ff[2]);
      t_sum = CHECK_WIDTH'(pw_ff[0]) + CHECK_WIDTH'(pw_ff[1]) + CHECK_WIDTH'(pw_ff[2]);
   end

   always_comb begin
      m_proj = v3_ax_ff | v3_ay_ff;
      nsh    = '0;
      for (int b = MAG_WIDTH; b < PROJ_WIDTH; b++) begin
         if (m_proj[b]) nsh = NORM_SHW'(b - MAG_WIDTH + 1);
      end
   end

   assign bx_prod = BX_WIDTH'(v5_ax_ff) * BX_WIDTH'(ryr);
   assign by_prod = BX_WIDTH'(v5_ay_ff) * BX_WIDTH'(rxr);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_valid_ff <= 1'b0;
         v1_valid_ff <= 1'b0;
         v2_valid_ff <= 1'b0;
         v3_valid_ff <= 1'b0;
         v4_valid_ff <= 1'b0;
         v5_valid_ff <= 1'b0;
         ctl_ff      <= '0;
      end else if (adv) begin
         v0_valid_ff <= in_valid;
         v1_valid_ff <= v0_valid_ff;
         v2_valid_ff <= v1_valid_ff;
         v3_valid_ff <= v2_valid_ff;
         v4_valid_ff <= v3_valid_ff;
         v5_valid_ff <= v4_valid_ff;
         ctl_ff.valid   <= v5_valid_ff;
         ctl_ff.zero    <= v5_zero_ff;
         ctl_ff.degen   <= (bx_prod == '0) && (by_prod == '0);
         ctl_ff.bx_zero <= (bx_prod == '0);
         ctl_ff.by_zero <= (by_prod == '0);
         ctl_ff.p_neg   <= v5_pneg_ff;
         ctl_ff.t_neg   <= v5_tneg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v0_ff      <= in_data;
         v1_zero_ff <= (ext[0] == '0) && (ext[1] == '0) && (ext[2] == '0);
         for (int k = 0; k < 3; k++) begin
            v1_ff[k] <= VEC_WIDTH'(ext_sh[k]);
            pu_ff[k] <= $signed(frame.u[k]) * v1_ff[k];
            ps_ff[k] <= $signed(frame.s[k]) * v1_ff[k];
            pw_ff[k] <= $signed(frame.w[k]) * v1_ff[k];
         end
         v2_zero_ff <= v1_zero_ff;
         v3_zero_ff <= v2_zero_ff;
         v3_pneg_ff <= p_sum[PROJ_WIDTH-1];
         v3_tneg_ff <= t_sum[CHECK_WIDTH-1];
         v3_ax_ff   <= p_sum[PROJ_WIDTH-1] ? PROJ_WIDTH'(-p_sum) : PROJ_WIDTH'(p_sum);
         v3_ay_ff   <= q_sum[PROJ_WIDTH-1] ? PROJ_WIDTH'(-q_sum) : PROJ_WIDTH'(q_sum);
         v4_zero_ff <= v3_zero_ff;
         v4_pneg_ff <= v3_pneg_ff;
         v4_tneg_ff <= v3_tneg_ff;
         v4_ax_ff   <= v3_ax_ff;
         v4_ay_ff   <= v3_ay_ff;
         v4_sh_ff   <= nsh;
         v5_zero_ff <= v4_zero_ff;
         v5_pneg_ff <= v4_pneg_ff;
         v5_tneg_ff <= v4_tneg_ff;
         v5_ax_ff   <= MAG_WIDTH'(v4_ax_ff >> v4_sh_ff);
         v5_ay_ff   <= MAG_WIDTH'(v4_ay_ff >> v4_sh_ff);
         bx_ff      <= bx_prod;
         by_ff      <= by_prod;
      end
   end

   assign ctl = ctl_ff;
   assign bx  = bx_ff;
   assign by  = by_ff;

endmodule

/* hw/rtl/efva_vec_stage.sv */
// ----------------------------------------------------------------------------
// Ellipse frame vector angle: vectoring stage
// Three CORDIC vectoring iterations with fixed shifts, then a register.
// ----------------------------------------------------------------------------
module efva_vec_stage
   import efva_pkg::*;
#(
   parameter int STEP0 = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  ctl_type              ctl_in,
   input  logic signed [CW-1:0] x_in,
   input  logic signed [CW-1:0] y_in,
   input  logic signed [ZW-1:0] z_in,
   output ctl_type              ctl_out,
   output logic signed [CW-1:0] x_out,
   output logic signed [CW-1:0] y_out,
   output logic signed [ZW-1:0] z_out
);

   logic signed [CW-1:0] xs [STEPS_PER_STAGE+1];
   logic signed [CW-1:0] ys [STEPS_PER_STAGE+1];
   logic signed [ZW-1:0] zs [STEPS_PER_STAGE+1];
   logic signed [ZW-1:0] at [STEPS_PER_STAGE];
   ctl_type              ctl_ff;
   logic signed [CW-1:0] x_ff, y_ff;
   logic signed [ZW-1:0] z_ff;

   always_comb begin
      xs[0] = x_in;
      ys[0] = y_in;
      zs[0] = z_in;
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
         at[k] = $signed(ZW'(atan_turn(STEP_WIDTH'(STEP0 + k))));
         if (!ys[k][CW-1]) begin
            xs[k+1] = xs[k] + (ys[k] >>> (STEP0 + k));
            ys[k+1] = ys[k] - (xs[k] >>> (STEP0 + k));
            zs[k+1] = zs[k] + at[k];
         end else begin
            xs[k+1] = xs[k] - (ys[k] >>> (STEP0 + k));
            ys[k+1] = ys[k] + (xs[k] >>> (STEP0 + k));
            zs[k+1] = zs[k] - at[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff <= xs[STEPS_PER_STAGE];
         y_ff <= ys[STEPS_PER_STAGE];
         z_ff <= zs[STEPS_PER_STAGE];
      end
   end

   assign ctl_out = ctl_ff;
   assign x_out   = x_ff;
   assign y_out   = y_ff;
   assign z_out   = z_ff;

endmodule

/* hw/rtl/ellipse_frame_vector_angle_core.sv */
// ----------------------------------------------------------------------------
// Ellipse frame vector angle core
// Polar angle of a Q16.16 vector in the plane of a tilted, rotated ellipse.
// ----------------------------------------------------------------------------
// One vector per clock while req_stall is low. From acceptance to the result
// register a transaction passes seven projection stages, ten vectoring stages
// of three CORDIC iterations each and the output stage. After reset and after
// every write to an angle register the frame builder, a single shared rotator
// and multiplier, runs, and req_stall stays high until it is done. Radius
// writes do not restart the frame builder.
// ----------------------------------------------------------------------------
`include "ellipse_frame_vector_angle_core_assert.svh"

module ellipse_frame_vector_angle_core
   import efva_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_type                    rsp_data,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   localparam logic signed [ZW-1:0] ZQUARTER = $signed({1'b0, QUARTER});
   localparam logic [ANGLE_BITS:0]  FULL_TURN = {1'b1, {ANGLE_BITS{1'b0}}};

   logic [RADIUS_WIDTH-1:0] radius_x_ff, radius_y_ff;
   logic [ANGLE_BITS-1:0]   tilt_ff, heading_ff, roll_ff;
   logic [MAG_WIDTH-1:0]    rxr_ff, ryr_ff, rxr_in, ryr_in;
   logic                    angle_write;
   logic                    frame_busy;
   frame_type               frame;
   logic                    adv;

   ctl_type              ctl_s [VEC_STAGES+1];
   logic signed [CW-1:0] x_s   [VEC_STAGES+1];
   logic signed [CW-1:0] y_s   [VEC_STAGES+1];
   logic signed [ZW-1:0] z_s   [VEC_STAGES+1];
   logic [BX_WIDTH-1:0]  bx, by;

   ctl_type                 fin;
   logic signed [ZW-1:0]    zf;
   logic [TURN_WIDTH-1:0]   zc, zm;
   logic [TURN_WIDTH:0]     zr;
   logic [ANGLE_BITS:0]     ang_h, ang_r;
   rsp_type                 rsp_in, rsp_ff;
   logic                    rsp_valid_ff;

   assign angle_write = csr_write && ((csr_index == CSR_TILT) ||
      (csr_index == CSR_HEADING) || (csr_index == CSR_ROLL));

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_x_ff <= RADIUS_WIDTH'(65536);
         radius_y_ff <= RADIUS_WIDTH'(65536);
         tilt_ff     <= '0;
         heading_ff  <= '0;
         roll_ff     <= '0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_RADIUS_X: radius_x_ff <= RADIUS_WIDTH'(csr_data);
            CSR_RADIUS_Y: radius_y_ff <= RADIUS_WIDTH'(csr_data);
            CSR_TILT:     tilt_ff     <= ANGLE_BITS'(csr_data);
            CSR_HEADING:  heading_ff  <= ANGLE_BITS'(csr_data);
            CSR_ROLL:     roll_ff     <= ANGLE_BITS'(csr_data);
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      priority if (radius_x_ff[31] || radius_y_ff[31]) begin
         rxr_in = MAG_WIDTH'(radius_x_ff >> 2);
         ryr_in = MAG_WIDTH'(radius_y_ff >> 2);
      end else if (radius_x_ff[30] || radius_y_ff[30]) begin
         rxr_in = MAG_WIDTH'(radius_x_ff >> 1);
         ryr_in = MAG_WIDTH'(radius_y_ff >> 1);
      end else begin
         rxr_in = MAG_WIDTH'(radius_x_ff);
         ryr_in = MAG_WIDTH'(radius_y_ff);
      end
   end

   always_ff @(posedge clock) begin
      rxr_ff <= rxr_in;
      ryr_ff <= ryr_in;
   end

   efva_frame u_frame (
      .clock         (clock),
      .reset         (reset),
      .start         (angle_write),
      .tilt_angle    (tilt_ff),
      .heading_angle (heading_ff),
      .roll_angle    (roll_ff),
      .frame         (frame),
      .busy          (frame_busy)
   );

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv || frame_busy;

   efva_project u_project (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid && !req_stall),
      .in_data  (req_data),
      .frame    (frame),
      .rxr      (rxr_ff),
      .ryr      (ryr_ff),
      .ctl      (ctl_s[0]),
      .bx       (bx),
      .by       (by)
   );

   assign x_s[0] = CW'(bx);
   assign y_s[0] = CW'(by);
   assign z_s[0] = '0;

   for (genvar g = 0; g < VEC_STAGES; g++) begin : g_vec
      efva_vec_stage #(
         .STEP0 (g * STEPS_PER_STAGE)
      ) u_vec (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .ctl_in  (ctl_s[g]),
         .x_in    (x_s[g]),
         .y_in    (y_s[g]),
         .z_in    (z_s[g]),
         .ctl_out (ctl_s[g+1]),
         .x_out   (x_s[g+1]),
         .y_out   (y_s[g+1]),
         .z_out   (z_s[g+1])
      );
   end

   always_comb begin
      fin = ctl_s[VEC_STAGES];
      zf  = z_s[VEC_STAGES];
      priority if (fin.by_zero) begin
         zc = '0;
      end else if (fin.bx_zero) begin
         zc = QUARTER;
      end else if (zf[ZW-1]) begin
         zc = '0;
      end else if (zf > ZQUARTER) begin
         zc = QUARTER;
      end else begin
         zc = TURN_WIDTH'(zf);
      end
      zm    = fin.p_neg ? (TURN_WIDTH'(QUARTER << 1) - zc) : zc;
      zr    = {1'b0, zm} + ((TURN_WIDTH+1)'(1) << (TURN_WIDTH - 1 - ANGLE_BITS));
      ang_h = zr[TURN_WIDTH -: (ANGLE_BITS+1)];
      ang_r = fin.t_neg ? (FULL_TURN - ang_h) : ang_h;
      priority if (fin.zero) begin
         rsp_in.plane_angle = '0;
         rsp_in.degenerate  = 1'b0;
      end else if (fin.degen) begin
         rsp_in.plane_angle = '0;
         rsp_in.degenerate  = 1'b1;
      end else begin
         rsp_in.plane_angle = ang_r[ANGLE_BITS-1:0];
         rsp_in.degenerate  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= fin.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `EFVA_ASSERT_IMPLIES(a_busy_stalls, frame_busy, req_stall)
   `EFVA_ASSERT_IMPLIES(a_degen_angle, rsp_valid && rsp_data.degenerate, rsp_data.plane_angle == '0)
   `EFVA_ASSERT_NEXT(a_angle_write_rebuild, angle_write, frame_busy && req_stall)

endmodule
